// File: rtl/core/frr_pkg.sv
package frr_pkg;

   typedef struct packed {
      logic [63:0] slope;
      logic [63:0] constant;
   } node_type;

   localparam logic [1:0] MODE_POINT = 2'd0;
   localparam logic [1:0] MODE_RADD  = 2'd1;
   localparam logic [1:0] MODE_RSUM  = 2'd2;
   localparam logic [1:0] MODE_KTH   = 2'd3;

endpackage

// File: rtl/core/fenwick_range_add_range_sum.sv
// Fenwick tree over 2^LOG_SIZE+1 positions with point add, range add, range sum and k-th search.
// After reset the block clears its node memory, one node a cycle, with busy high.
// A request is taken when start is high and busy is low; busy stays high until the
// single result appears, for exactly one cycle, with rsp_valid.
// The receiver cannot stall; results must be taken as they come. Time per request is
// set by the walk over the node memory (one read and one write port), one node a cycle
// for adds and sums: a point add is one walk, a range add S_RMUL and two such walks, a
// range sum two prefix walks, each followed by S_PMUL and S_PFIN, and a k-th search
// reads and tests one node per bit in S_KRD and S_KDEC, from bit LOG_SIZE down to 0.
module fenwick_range_add_range_sum #(
   parameter int LOG_SIZE = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [10:0]        req_left,
   input  logic [10:0]        req_right,
   input  logic signed [63:0] req_amount,
   input  logic signed [63:0] req_slope,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_total,
   output logic [10:0]        rsp_found_index
);
   import frr_pkg::*;

   localparam int AW = LOG_SIZE + 1;
   localparam int PW = (LOG_SIZE + 2 > 12) ? LOG_SIZE + 2 : 12;
   localparam int BW = $clog2(LOG_SIZE + 1);
   localparam int DEPTH = (1 << LOG_SIZE) + 1;
   localparam logic [PW-1:0] NODES = PW'(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RMUL  = 4'd2;
   localparam logic [3:0] S_PADD  = 4'd3;
   localparam logic [3:0] S_PSUM  = 4'd4;
   localparam logic [3:0] S_PMUL  = 4'd5;
   localparam logic [3:0] S_PFIN  = 4'd6;
   localparam logic [3:0] S_KRD   = 4'd7;
   localparam logic [3:0] S_KDEC  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [PW-1:0] left_ff, left_in, right_ff, right_in;
   logic [63:0]   amt_ff, amt_in;
   logic [63:0]   add_s_ff, add_s_in, add_c_ff, add_c_in;
   logic [PW-1:0] pos_ff, pos_in, end_ff, end_in;
   logic          pend_ff, pend_in, second_ff, second_in, kvalid_ff, kvalid_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in, clr_ff, clr_in;
   logic [63:0]   acc_s_ff, acc_s_in, acc_c_ff, acc_c_in;
   logic [63:0]   prod_ff, prod_in, first_ff, first_in, k_ff, k_in;
   logic [AW-1:0] res_ff, res_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_total_ff, rsp_total_in;
   logic [10:0]   rsp_found_ff, rsp_found_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   node_type      rd_data, wr_data;

   logic [PW-1:0] idx;
   logic [63:0]   val;
   logic [AW-1:0] res_next;

   function automatic logic [PW-1:0] clamp_end(input logic [PW-1:0] e);
      return (e > NODES) ? NODES : e;
   endfunction

   frr_node_ram #(.ADDR_W(AW), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      amt_in       = amt_ff;
      add_s_in     = add_s_ff;
      add_c_in     = add_c_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      second_in    = second_ff;
      kvalid_in    = kvalid_ff;
      pend_addr_in = pend_addr_ff;
      clr_in       = clr_ff;
      acc_s_in     = acc_s_ff;
      acc_c_in     = acc_c_ff;
      prod_in      = prod_ff;
      first_in     = first_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      rsp_found_in = rsp_found_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = '{slope: rd_data.slope + add_s_ff, constant: rd_data.constant + add_c_ff};
      idx          = '0;
      val          = prod_ff + acc_c_ff;
      res_next     = res_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               left_in   = PW'(req_left);
               right_in  = PW'(req_right);
               amt_in    = req_amount;
               pend_in   = 1'b0;
               second_in = 1'b0;
               case (req_mode)
                  MODE_POINT: begin
                     add_s_in = req_slope;
                     add_c_in = req_amount;
                     pos_in   = PW'(req_left);
                     state_in = S_PADD;
                  end
                  MODE_RADD: begin
                     state_in = S_RMUL;
                  end
                  MODE_RSUM: begin
                     end_in   = clamp_end(PW'(req_right) + PW'(1));
                     pos_in   = clamp_end(PW'(req_right) + PW'(1));
                     acc_s_in = '0;
                     acc_c_in = '0;
                     state_in = S_PSUM;
                  end
                  default: begin
                     k_in     = req_amount;
                     res_in   = '0;
                     bit_in   = BW'(LOG_SIZE);
                     state_in = S_KRD;
                  end
               endcase
            end
         end
         S_RMUL: begin
            add_s_in  = amt_ff;
            add_c_in  = amt_ff - 64'(amt_ff * 64'(left_ff));
            prod_in   = 64'(amt_ff * 64'(right_ff));
            pos_in    = left_ff;
            second_in = 1'b1;
            state_in  = S_PADD;
         end
         S_PADD: begin
            wr_en = pend_ff;
            if (pos_ff < NODES) begin
               rd_en        = 1'b1;
               rd_addr      = pos_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = pos_ff[AW-1:0];
               pos_in       = pos_ff | (pos_ff + PW'(1));
            end else begin
               pend_in = 1'b0;
               if (second_ff) begin
                  add_s_in  = 64'd0 - amt_ff;
                  add_c_in  = prod_ff;
                  pos_in    = right_ff;
                  second_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_total_in = '0;
                  rsp_found_in = '0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_PSUM: begin
            if (pend_ff) begin
               acc_s_in = acc_s_ff + rd_data.slope;
               acc_c_in = acc_c_ff + rd_data.constant;
            end
            if (pos_ff != '0) begin
               idx     = pos_ff - PW'(1);
               rd_en   = 1'b1;
               rd_addr = idx[AW-1:0];
               pos_in  = idx & (idx + PW'(1));
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            prod_in  = 64'(acc_s_ff * 64'(end_ff - PW'(1)));
            state_in = S_PFIN;
         end
         S_PFIN: begin
            if (!second_ff) begin
               first_in  = val;
               end_in    = clamp_end(left_ff);
               pos_in    = clamp_end(left_ff);
               acc_s_in  = '0;
               acc_c_in  = '0;
               second_in = 1'b1;
               state_in  = S_PSUM;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_total_in = first_ff - val;
               rsp_found_in = '0;
               state_in     = S_IDLE;
            end
         end
         S_KRD: begin
            idx = PW'(res_ff) + (PW'(1) << bit_ff) - PW'(1);
            if (idx < NODES) begin
               rd_en     = 1'b1;
               rd_addr   = idx[AW-1:0];
               kvalid_in = 1'b1;
            end else begin
               kvalid_in = 1'b0;
            end
            state_in = S_KDEC;
         end
         S_KDEC: begin
            if (kvalid_ff && ($signed(rd_data.constant) < $signed(k_ff))) begin
               k_in     = k_ff - rd_data.constant;
               res_next = res_ff + (AW'(1) << bit_ff);
            end
            res_in = res_next;
            if (bit_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = '0;
               rsp_found_in = 11'(res_next);
               state_in     = S_IDLE;
            end else begin
               bit_in   = bit_ff - BW'(1);
               state_in = S_KRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         second_ff    <= 1'b0;
         kvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         second_ff    <= second_in;
         kvalid_ff    <= kvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      amt_ff       <= amt_in;
      add_s_ff     <= add_s_in;
      add_c_ff     <= add_c_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      acc_s_ff     <= acc_s_in;
      acc_c_ff     <= acc_c_in;
      prod_ff      <= prod_in;
      first_ff     <= first_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      rsp_total_ff <= rsp_total_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total       = rsp_total_ff;
   assign rsp_found_index = rsp_found_ff;

endmodule

// File: rtl/core/frr_node_ram.sv
module frr_node_ram #(
   parameter int ADDR_W = 11,
   parameter int DEPTH  = 1025
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output frr_pkg::node_type rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  frr_pkg::node_type wr_data
);
   import frr_pkg::*;

   node_type mem [DEPTH];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/frr_checker.sv
module frr_checker #(
   parameter int LOG_SIZE = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [10:0] req_left,
   input  logic [10:0] req_right,
   input  logic [63:0] req_amount,
   input  logic [63:0] req_slope,
   input  logic        rsp_valid,
   input  logic [63:0] rsp_total,
   input  logic [10:0] rsp_found_index,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import frr_pkg::*;

   localparam int NODES = (1 << LOG_SIZE) + 1;

   typedef struct packed {
      logic [63:0] total;
      logic [10:0] found_index;
   } answer_type;

   logic [63:0] slope_tree [NODES];
   logic [63:0] const_tree [NODES];
   answer_type  answer_q [$];

   function automatic logic signed_lt(logic [63:0] a, logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   task automatic tree_add(int pos, logic [63:0] s, logic [63:0] c);
      while (pos < NODES) begin
         slope_tree[pos] += s;
         const_tree[pos] += c;
         pos = pos | (pos + 1);
      end
   endtask

   function automatic logic [63:0] prefix_sum(int upto);
      logic [63:0] s;
      logic [63:0] c;
      int          p;
      int          idx;
      s = '0;
      c = '0;
      if (upto == 0) return '0;
      if (upto > NODES) upto = NODES;
      p = upto;
      while (p > 0) begin
         idx = p - 1;
         s += slope_tree[idx];
         c += const_tree[idx];
         p = idx & (idx + 1);
      end
      return s * 64'(upto - 1) + c;
   endfunction

   function automatic logic [10:0] kth_find(logic [63:0] k);
      int res;
      int idx;
      res = 0;
      for (int i = LOG_SIZE; i >= 0; i--) begin
         idx = res + (1 << i) - 1;
         if (idx < NODES && signed_lt(const_tree[idx], k)) begin
            k -= const_tree[idx];
            res += 1 << i;
         end
      end
      return 11'(res);
   endfunction

   always @(posedge clock) begin
      answer_type a;
      answer_type got;
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            slope_tree[i] = '0;
            const_tree[i] = '0;
         end
         answer_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (rsp_valid) begin
            got.total = rsp_total;
            got.found_index = rsp_found_index;
            if (answer_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h %0d", rsp_total,
                                             rsp_found_index);
               fail_count <= fail_count + 1;
            end else begin
               a = answer_q.pop_front();
               if (a !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: exp total %h idx %0d, got total %h idx %0d",
                              a.total, a.found_index, got.total, got.found_index);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            a = '0;
            case (req_mode)
               MODE_POINT: tree_add(int'(req_left), req_slope, req_amount);
               MODE_RADD: begin
                  tree_add(int'(req_left), req_amount,
                           (64'd1 - 64'(req_left)) * req_amount);
                  tree_add(int'(req_right), 64'd0 - req_amount, 64'(req_right) * req_amount);
               end
               MODE_RSUM: a.total = prefix_sum(int'(req_right) + 1) -
                                    prefix_sum(int'(req_left));
               default: a.found_index = kth_find(req_amount);
            endcase
            answer_q = {answer_q, a};
         end
         pending <= answer_q.size();
      end
   end
endmodule

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import frr_pkg::*;

   localparam int LIMIT = 2_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_mode = MODE_POINT;
   logic [10:0] req_left = '0;
   logic [10:0] req_right = '0;
   logic [63:0] req_amount = '0;
   logic [63:0] req_slope = '0;
   logic        rsp_valid;
   logic signed [63:0] rsp_total;
   logic [10:0] rsp_found_index;
   int          fail_count;
   int          pending;
   int          cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   fenwick_range_add_range_sum u_dut (
      .clock, .reset, .start, .busy, .req_mode, .req_left, .req_right,
      .req_amount, .req_slope, .rsp_valid, .rsp_total, .rsp_found_index
   );

   frr_checker u_chk (
      .clock, .reset, .start, .busy, .req_mode, .req_left, .req_right,
      .req_amount, .req_slope, .rsp_valid, .rsp_total,
      .rsp_found_index, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** fenwick_range_add_range_sum: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'(int'($urandom_range(0, 20)) - 10);
         3: return {$urandom, $urandom};
         default: return 64'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic logic [10:0] rand_pos();
      case ($urandom_range(0, 7))
         0: return 11'd1024;
         1: return 11'($urandom);
         2: return 11'd0;
         default: return 11'($urandom_range(0, 1024));
      endcase
   endfunction

   task automatic send(logic [1:0] m, logic [10:0] l, logic [10:0] r,
                       logic [63:0] a, logic [63:0] s);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1;
      req_mode   <= m;
      req_left   <= l;
      req_right  <= r;
      req_amount <= a;
      req_slope  <= s;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      logic [1:0] m;
      logic [10:0] l;
      logic [10:0] r;
      repeat (2) @(posedge clock);
      reset <= 0;
      send(MODE_POINT, 11'd0, 11'd0, 64'd5, 64'd0);
      send(MODE_POINT, 11'd1024, 11'd0, 64'd7, 64'd0);
      send(MODE_POINT, 11'd2047, 11'd0, 64'hffff_ffff_ffff_ffff, 64'd3);
      send(MODE_KTH, 11'd0, 11'd0, 64'd6, 64'd0);
      send(MODE_KTH, 11'd0, 11'd0, 64'h7fff_ffff_ffff_ffff, 64'd0);
      send(MODE_KTH, 11'd0, 11'd0, 64'h8000_0000_0000_0000, 64'd0);
      send(MODE_RSUM, 11'd0, 11'd1024, 64'd0, 64'd0);
      send(MODE_RSUM, 11'd0, 11'd2047, 64'd0, 64'd0);
      send(MODE_RADD, 11'd0, 11'd1024, 64'h7fff_ffff_ffff_ffff, 64'd0);
      send(MODE_RADD, 11'd3, 11'd2047, 64'h8000_0000_0000_0000, 64'd0);
      send(MODE_RADD, 11'd500, 11'd10, 64'd9, 64'd0);
      send(MODE_RADD, 11'd1500, 11'd2000, 64'd9, 64'hffff_ffff_ffff_ffff);
      send(MODE_RSUM, 11'd0, 11'd0, 64'd0, 64'd0);
      send(MODE_RSUM, 11'd900, 11'd20, 64'd0, 64'd0);
      send(MODE_RSUM, 11'd2047, 11'd2047, 64'hffff_ffff_ffff_ffff, 64'd1);
      send(MODE_RSUM, 11'd5, 11'd700, 64'd0, 64'd0);
      send(MODE_POINT, 11'd512, 11'd7, 64'd1, 64'h8000_0000_0000_0000);
      send(MODE_RSUM, 11'd1, 11'd1023, 64'd0, 64'd0);
      for (int i = 0; i < 1900; i++) begin
         m = 2'($urandom);
         l = rand_pos();
         r = ($urandom_range(0, 4) == 0) ? rand_pos() : 11'($urandom_range(l, 1024));
         send(m, l, r, rand64(), rand64());
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("** fenwick_range_add_range_sum: PASSED **");
      else
         $display("** fenwick_range_add_range_sum: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/frr_pkg.sv
rtl/core/frr_node_ram.sv
rtl/core/fenwick_range_add_range_sum.sv
bench/frr_checker.sv
bench/tb_top.sv
